// ----- hw/rtl/frbq_pkg.sv -----
// shared types and codes for the ready / blocked thread queue block
// no dependencies; imported by frbq_ctrl and fifo_ready_and_blocked_queue
package frbq_pkg;

  // operation selector carried in the input tuser
  typedef enum logic [2:0] {
    MODE_ADD       = 3'd0,
    MODE_YIELD     = 3'd1,
    MODE_RESUME    = 3'd2,
    MODE_TERMINATE = 3'd3,
    MODE_ADD_BLOCK = 3'd4
  } mode_t;

  // per-operation status code
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned TOTAL_W = 5;

  // one result word as handed from the controller to the output stage
  typedef struct packed {
    logic                dispatch_valid;
    logic [ID_W-1:0]     dispatch_id;
    status_t             status;
    logic [TOTAL_W-1:0]  ready_total;
    logic [TOTAL_W-1:0]  blocked_total;
  } result_t;

endpackage

// ----- hw/rtl/frbq_ram.sv -----
// synchronous id store: one write port, one read port, registered read data
// no package dependencies; instantiated twice by the top level
module frbq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/frbq_ctrl.sv -----
// sequencer for the two circular id queues: pointers, counts and operation steps
// depends on frbq_pkg; drives the ready and blocked frbq_ram instances
module frbq_ctrl
  import frbq_pkg::*;
#(
  parameter int unsigned READY_DEPTH   = 16,
  parameter int unsigned BLOCKED_DEPTH = 16,
  parameter int unsigned RAW           = $clog2(READY_DEPTH),
  parameter int unsigned BAW           = $clog2(BLOCKED_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  // operation request
  input  logic             req_valid,
  output logic             req_ready,
  input  mode_t            req_mode,
  input  logic [ID_W-1:0]  req_id,
  input  logic             req_disk_ready,
  // result toward the output stage
  output logic             res_valid,
  input  logic             res_free,
  output result_t          res,
  // ready queue memory
  output logic             r_we,
  output logic [RAW-1:0]   r_waddr,
  output logic [ID_W-1:0]  r_wdata,
  output logic [RAW-1:0]   r_raddr,
  input  logic [ID_W-1:0]  r_rdata,
  // blocked queue memory
  output logic             b_we,
  output logic [BAW-1:0]   b_waddr,
  output logic [ID_W-1:0]  b_wdata,
  output logic [BAW-1:0]   b_raddr,
  input  logic [ID_W-1:0]  b_rdata
);

  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);
  localparam int unsigned BCW = $clog2(BLOCKED_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YIELD,
    S_RELEASE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [RAW-1:0]      rhead_r, rhead_nxt;
  logic [RCW-1:0]      rcnt_r, rcnt_nxt;
  logic [BAW-1:0]      bhead_r, bhead_nxt;
  logic [BCW-1:0]      bcnt_r, bcnt_nxt;
  logic [RAW-1:0]      idx_r, idx_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic                dv_r, dv_nxt;
  logic [ID_W-1:0]     did_r, did_nxt;
  status_t             status_r, status_nxt;

  logic [RAW:0]        rcnt_ext;
  logic [RAW:0]        idx_inc;
  logic [RAW-1:0]      r_tail;
  logic [BAW-1:0]      b_tail;
  logic                r_full;
  logic                r_room2;

  // ring address: head plus offset, folded once past the depth
  function automatic logic [RAW-1:0] r_wrap(input logic [RAW-1:0] head,
                                             input logic [RAW:0]   ofs);
    logic [RAW:0] s;
    s = {1'b0, head} + ofs;
    if (s >= (RAW+1)'(READY_DEPTH)) begin
      s = s - (RAW+1)'(READY_DEPTH);
    end
    return s[RAW-1:0];
  endfunction

  function automatic logic [BAW-1:0] b_wrap(input logic [BAW-1:0] head,
                                             input logic [BAW:0]   ofs);
    logic [BAW:0] s;
    s = {1'b0, head} + ofs;
    if (s >= (BAW+1)'(BLOCKED_DEPTH)) begin
      s = s - (BAW+1)'(BLOCKED_DEPTH);
    end
    return s[BAW-1:0];
  endfunction

  // tail addresses and fill checks
  assign rcnt_ext = (RAW+1)'(rcnt_r);
  assign idx_inc  = {1'b0, idx_r} + (RAW+1)'(1);
  assign r_tail   = r_wrap(rhead_r, rcnt_ext);
  assign b_tail   = b_wrap(bhead_r, (BAW+1)'(bcnt_r));
  assign r_full   = (rcnt_ext == (RAW+1)'(READY_DEPTH));
  assign r_room2  = ((rcnt_ext + (RAW+1)'(1)) < (RAW+1)'(READY_DEPTH));

  // operation sequencing
  always_comb begin
    state_nxt  = state_r;
    rhead_nxt  = rhead_r;
    rcnt_nxt   = rcnt_r;
    bhead_nxt  = bhead_r;
    bcnt_nxt   = bcnt_r;
    idx_nxt    = idx_r;
    id_nxt     = id_r;
    dv_nxt     = dv_r;
    did_nxt    = did_r;
    status_nxt = status_r;

    r_we    = 1'b0;
    r_waddr = r_tail;
    r_wdata = id_r;
    r_raddr = rhead_r;
    b_we    = 1'b0;
    b_waddr = b_tail;
    b_wdata = id_r;
    b_raddr = bhead_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          id_nxt     = req_id;
          dv_nxt     = 1'b0;
          did_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (req_mode)
            MODE_ADD: begin
              if (r_full) begin
                status_nxt = ST_FULL;
              end else begin
                r_we     = 1'b1;
                r_wdata  = req_id;
                rcnt_nxt = rcnt_r + RCW'(1);
              end
            end
            MODE_YIELD: begin
              if (rcnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_YIELD;
              end
            end
            MODE_RESUME: begin
              if (r_full) begin
                status_nxt = ST_FULL;
              end else begin
                r_we     = 1'b1;
                r_wdata  = req_id;
                rcnt_nxt = rcnt_r + RCW'(1);
                if (bcnt_r != '0 && req_disk_ready) begin
                  if (r_room2) begin
                    state_nxt = S_RELEASE;
                  end else begin
                    status_nxt = ST_FULL;
                  end
                end
              end
            end
            MODE_TERMINATE: begin
              if (rcnt_r == '0) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_ADD_BLOCK: begin
              if (bcnt_r == BCW'(BLOCKED_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                b_we     = 1'b1;
                b_wdata  = req_id;
                bcnt_nxt = bcnt_r + BCW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // head word arrives, pop it
      S_YIELD: begin
        dv_nxt    = 1'b1;
        did_nxt   = r_rdata;
        rhead_nxt = r_wrap(rhead_r, (RAW+1)'(1));
        rcnt_nxt  = rcnt_r - RCW'(1);
        state_nxt = S_DONE;
      end

      // blocked head arrives, append it behind the resumed id
      S_RELEASE: begin
        r_we      = 1'b1;
        r_wdata   = b_rdata;
        rcnt_nxt  = rcnt_r + RCW'(1);
        bhead_nxt = b_wrap(bhead_r, (BAW+1)'(1));
        bcnt_nxt  = bcnt_r - BCW'(1);
        state_nxt = S_DONE;
      end

      // one entry per cycle: compare idx while reading idx+1
      S_SCAN: begin
        r_raddr = r_wrap(rhead_r, idx_inc);
        if (r_rdata == id_r) begin
          if (idx_r == '0) begin
            rhead_nxt = r_wrap(rhead_r, (RAW+1)'(1));
            rcnt_nxt  = rcnt_r - RCW'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else if (idx_inc == rcnt_ext) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_inc[RAW-1:0];
        end
      end

      // close the gap: fetch the entry behind the hole
      S_SHIFT_RD: begin
        r_raddr = r_wrap(rhead_r, idx_inc);
        if (idx_inc < rcnt_ext) begin
          state_nxt = S_SHIFT_WR;
        end else begin
          rcnt_nxt  = rcnt_r - RCW'(1);
          state_nxt = S_DONE;
        end
      end

      S_SHIFT_WR: begin
        r_we      = 1'b1;
        r_waddr   = r_wrap(rhead_r, {1'b0, idx_r});
        r_wdata   = r_rdata;
        idx_nxt   = idx_inc[RAW-1:0];
        state_nxt = S_SHIFT_RD;
      end

      // hold the result until the output register can take it
      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, pointers and result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rhead_r <= '0;
      rcnt_r  <= '0;
      bhead_r <= '0;
      bcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rhead_r <= rhead_nxt;
      rcnt_r  <= rcnt_nxt;
      bhead_r <= bhead_nxt;
      bcnt_r  <= bcnt_nxt;
    end
    idx_r    <= idx_nxt;
    id_r     <= id_nxt;
    dv_r     <= dv_nxt;
    did_r    <= did_nxt;
    status_r <= status_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // totals are the low bits of the counts after the operation
  assign res.dispatch_valid = dv_r;
  assign res.dispatch_id    = did_r;
  assign res.status         = status_r;
  assign res.ready_total    = TOTAL_W'(rcnt_r);
  assign res.blocked_total  = TOTAL_W'(bcnt_r);

endmodule

// ----- hw/rtl/fifo_ready_and_blocked_queue.sv -----
// Thread scheduler queues: a FIFO ready queue and a FIFO blocked queue of 8-bit
// thread ids, each held in a synchronous ring memory with head pointer and count.
// The input word's tuser selects add, yield, resume, terminate or add-to-blocked;
// every accepted word gives exactly one result word. Yield and a releasing resume
// wait for the registered read data of the id memories. Terminate walks the ready
// ring one entry per cycle until it finds the id or passes the last entry. A match
// at the head is popped; a match behind it closes the gap by reading each later
// entry and writing it one place toward the head. An id that is not found gives
// ST_NOTFOUND. The resume release models the disk data-request bit (0x08 of status
// port 0x1F7) as the disk_ready input bit. No clearing pass is needed after reset;
// the ring contents are only used below the fill count.
// depends on frbq_pkg, frbq_ctrl and frbq_ram
module fifo_ready_and_blocked_queue
  import frbq_pkg::*;
#(
  parameter int unsigned READY_DEPTH   = 16,
  parameter int unsigned BLOCKED_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] thread_id, [8] disk_ready, [15:9] zero
  input  logic [2:0]  in_tuser,   // [2:0] mode
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] dispatch_valid, [8:1] dispatch_id,
                                  // [10:9] status, [15:11] ready_total,
                                  // [20:16] blocked_total, [23:21] zero
);

  localparam int unsigned RAW = $clog2(READY_DEPTH);
  localparam int unsigned BAW = $clog2(BLOCKED_DEPTH);

  logic             res_valid;
  logic             res_free;
  result_t          res;
  logic             r_we;
  logic [RAW-1:0]   r_waddr;
  logic [ID_W-1:0]  r_wdata;
  logic [RAW-1:0]   r_raddr;
  logic [ID_W-1:0]  r_rdata;
  logic             b_we;
  logic [BAW-1:0]   b_waddr;
  logic [ID_W-1:0]  b_wdata;
  logic [BAW-1:0]   b_raddr;
  logic [ID_W-1:0]  b_rdata;
  logic             out_valid_r;
  result_t          out_res_r;

  // queue sequencer
  frbq_ctrl #(
    .READY_DEPTH   (READY_DEPTH),
    .BLOCKED_DEPTH (BLOCKED_DEPTH),
    .RAW           (RAW),
    .BAW           (BAW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_tvalid),
    .req_ready      (in_tready),
    .req_mode       (mode_t'(in_tuser)),
    .req_id         (in_tdata[7:0]),
    .req_disk_ready (in_tdata[8]),
    .res_valid      (res_valid),
    .res_free       (res_free),
    .res            (res),
    .r_we           (r_we),
    .r_waddr        (r_waddr),
    .r_wdata        (r_wdata),
    .r_raddr        (r_raddr),
    .r_rdata        (r_rdata),
    .b_we           (b_we),
    .b_waddr        (b_waddr),
    .b_wdata        (b_wdata),
    .b_raddr        (b_raddr),
    .b_rdata        (b_rdata)
  );

  // ready queue ring
  frbq_ram #(
    .DEPTH (READY_DEPTH),
    .AW    (RAW),
    .DW    (ID_W)
  ) u_ready_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // blocked queue ring
  frbq_ram #(
    .DEPTH (BLOCKED_DEPTH),
    .AW    (BAW),
    .DW    (ID_W)
  ) u_blocked_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // output register, frees the sequencer while a word waits downstream
  assign res_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.blocked_total,
                       out_res_r.ready_total,
                       out_res_r.status,
                       out_res_r.dispatch_id,
                       out_res_r.dispatch_valid};

endmodule
